/* design/oaee_pkg.sv */
`timescale 1ns / 1ps

package oaee_pkg;

   localparam int CMD_W  = 3;
   localparam int POS_W  = 7;
   localparam int DATA_W = 32;
   localparam int STAT_W = 3;
   localparam int IDX_W  = 6;
   localparam int CNT_W  = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT   = 3'd0,
      CMD_DELETE   = 3'd1,
      CMD_UPDATE   = 3'd2,
      CMD_SEARCH   = 3'd3,
      CMD_TRAVERSE = 3'd4
   } cmd_code_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 3'd0,
      ST_BAD_POS   = 3'd1,
      ST_FULL      = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EDIT,
      S_SEARCH,
      S_TRAV
   } state_type;

   typedef struct packed {
      logic [CMD_W-1:0]         cmd;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic [IDX_W-1:0]         index;
      logic signed [DATA_W-1:0] data;
      logic                     last;
      logic [CNT_W-1:0]         count;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic match_load;
      logic edit;
      logic search_rsp;
      logic trav_clear;
      logic trav_step;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
      logic trav_last;
   } dp_stat_type;

endpackage

/* design/oaee_ctrl.sv */
`timescale 1ns / 1ps

module oaee_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept_i,
   input  logic [oaee_pkg::CMD_W-1:0] cmd_i,
   input  oaee_pkg::dp_stat_type      stat_i,
   output oaee_pkg::dp_cmd_type       dp_cmd_o,
   output logic                       busy_o
);
   import oaee_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      dp_cmd_o = '0;
      busy_o   = 1'b1;
      case (state_ff)
         S_IDLE: begin
            busy_o = 1'b0;
            if (accept_i) begin
               dp_cmd_o.capture = 1'b1;
               case (cmd_i)
                  CMD_INSERT, CMD_DELETE, CMD_UPDATE: begin
                     state_in = S_EDIT;
                  end
                  CMD_SEARCH: begin
                     dp_cmd_o.match_load = 1'b1;
                     state_in            = S_SEARCH;
                  end
                  CMD_TRAVERSE: begin
                     dp_cmd_o.trav_clear = 1'b1;
                     state_in            = S_TRAV;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_EDIT: begin
            dp_cmd_o.edit = 1'b1;
            state_in      = S_IDLE;
         end
         S_SEARCH: begin
            dp_cmd_o.search_rsp = 1'b1;
            state_in            = S_IDLE;
         end
         S_TRAV: begin
            dp_cmd_o.trav_step = 1'b1;
            if (stat_i.empty || stat_i.trav_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

/* design/oaee_dpath.sv */
`timescale 1ns / 1ps

module oaee_dpath #(
   parameter int DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  oaee_pkg::req_type     req_i,
   input  oaee_pkg::dp_cmd_type  cmd_i,
   output oaee_pkg::dp_stat_type stat_o,
   output logic                  rsp_strobe_o,
   output oaee_pkg::rsp_type     rsp_o
);
   import oaee_pkg::*;

   req_type                  req_ff;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         trav_ff, trav_in;
   logic [DEPTH-1:0]         match_ff, match_in;
   logic signed [DATA_W-1:0] cells_ff [DEPTH];
   logic signed [DATA_W-1:0] cells_in [DEPTH];
   rsp_type                  rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   status_type       edit_status;
   logic             do_ins, do_del, do_upd;
   logic             found;
   logic [IDX_W-1:0] hit_idx;
   logic             trav_last;

   // edit checks against the live count
   always_comb begin
      case (req_ff.cmd)
         CMD_INSERT: begin
            if (req_ff.position > count_ff) begin
               edit_status = ST_BAD_POS;
            end else if (count_ff == CNT_W'(DEPTH)) begin
               edit_status = ST_FULL;
            end else begin
               edit_status = ST_OK;
            end
         end
         CMD_DELETE, CMD_UPDATE: begin
            edit_status = (req_ff.position >= count_ff) ? ST_BAD_POS : ST_OK;
         end
         default: begin
            edit_status = ST_OK;
         end
      endcase
   end

   assign do_ins = cmd_i.edit && (edit_status == ST_OK) && (req_ff.cmd == CMD_INSERT);
   assign do_del = cmd_i.edit && (edit_status == ST_OK) && (req_ff.cmd == CMD_DELETE);
   assign do_upd = cmd_i.edit && (edit_status == ST_OK) && (req_ff.cmd == CMD_UPDATE);

   always_comb begin
      count_in = count_ff;
      if (do_ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_del) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // cell chain: each cell sees only its neighbors and the head cell
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam int Up = (i < DEPTH - 1) ? i + 1 : i;
      localparam int Dn = (i > 0) ? i - 1 : 0;

      always_comb begin
         cells_in[i] = cells_ff[i];
         if (do_ins) begin
            if (req_ff.position == CNT_W'(i)) begin
               cells_in[i] = req_ff.value;
            end else if (req_ff.position < CNT_W'(i)) begin
               cells_in[i] = cells_ff[Dn];
            end
         end else if (do_del) begin
            if (req_ff.position <= CNT_W'(i)) begin
               cells_in[i] = cells_ff[Up];
            end
         end else if (do_upd) begin
            if (req_ff.position == CNT_W'(i)) begin
               cells_in[i] = req_ff.value;
            end
         end else if (cmd_i.trav_step) begin
            // rotate the live part by one, head wraps to the tail
            if (CNT_W'(i) < count_ff) begin
               if (CNT_W'(i) + CNT_W'(1) == count_ff) begin
                  cells_in[i] = cells_ff[0];
               end else begin
                  cells_in[i] = cells_ff[Up];
               end
            end
         end
      end

      assign match_in[i] = (cells_ff[i] == req_i.value) && (CNT_W'(i) < count_ff);
   end

   // lowest matching slot
   always_comb begin
      found   = 1'b0;
      hit_idx = '0;
      for (int k = DEPTH - 1; k >= 0; k--) begin
         if (match_ff[k]) begin
            found   = 1'b1;
            hit_idx = IDX_W'(k);
         end
      end
   end

   assign trav_last = (trav_ff + CNT_W'(1) == count_ff);

   always_comb begin
      trav_in = trav_ff;
      if (cmd_i.trav_clear) begin
         trav_in = '0;
      end else if (cmd_i.trav_step) begin
         trav_in = trav_ff + CNT_W'(1);
      end
   end

   always_comb begin
      rsp_in       = '0;
      rsp_in.count = count_in;
      rsp_valid_in = 1'b0;
      if (cmd_i.edit) begin
         rsp_valid_in  = 1'b1;
         rsp_in.status = edit_status;
         rsp_in.last   = 1'b1;
      end else if (cmd_i.search_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_in.status = found ? ST_OK : ST_NOT_FOUND;
         rsp_in.index  = found ? hit_idx : '0;
         rsp_in.last   = 1'b1;
      end else if (cmd_i.trav_step) begin
         rsp_valid_in = 1'b1;
         if (count_ff == '0) begin
            rsp_in.status = ST_EMPTY;
            rsp_in.last   = 1'b1;
         end else begin
            rsp_in.status = ST_OK;
            rsp_in.index  = trav_ff[IDX_W-1:0];
            rsp_in.data   = cells_ff[0];
            rsp_in.last   = trav_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         trav_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         trav_ff      <= trav_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.capture) begin
         req_ff <= req_i;
      end
      if (cmd_i.match_load) begin
         match_ff <= match_in;
      end
      rsp_ff   <= rsp_in;
      cells_ff <= cells_in;
   end

   assign stat_o.empty     = (count_ff == '0);
   assign stat_o.trav_last = trav_last;
   assign rsp_strobe_o     = rsp_valid_ff;
   assign rsp_o            = rsp_ff;

endmodule

/* design/ordered_array_edit_engine_unit.sv */
`timescale 1ns / 1ps

// ordered array edit engine: up to DEPTH signed 32-bit entries kept in a
// chain of cells plus a live count
// - command channel: a beat on req_beat is taken at a clock edge with start
//   high and busy low; cmd codes 5 to 7 are dropped with no response
// - response channel: each result beat sits on rsp_beat for one cycle with
//   rsp_strobe high; the receiver has no way to stall, so it must take
//   every beat as it comes; last marks the final beat of a command
// - insert, delete, update and search give one beat, registered through the
//   EDIT or SEARCH state and the response register; busy is high for one
//   cycle, so a new command can be taken as soon as that beat appears
// - traverse gives one beat per live entry, one per cycle, through the TRAV
//   state and the response register; busy stays high until the final beat
//   is registered (an empty array answers with a single empty beat)
// - the shift for insert and delete and the compare for search run across
//   all cells at once; traverse rotates the live cells past the head cell
//   and leaves them in order when done
// - synchronous reset empties the array and drops any command in flight;
//   stored entries keep their old contents but are never read until written

module ordered_array_edit_engine_unit #(
   parameter int DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  oaee_pkg::req_type req_beat,
   output logic              rsp_strobe,
   output oaee_pkg::rsp_type rsp_beat
);
   import oaee_pkg::*;

   logic        accept;
   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   // a command beat moves when start is up and the engine is idle
   assign accept = start && !busy;

   // sequencer: decides which datapath operation runs each cycle
   oaee_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept_i (accept),
      .cmd_i    (req_beat.cmd),
      .stat_i   (dp_stat),
      .dp_cmd_o (dp_cmd),
      .busy_o   (busy)
   );

   // cell chain, live count, match vector and registered response
   oaee_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .req_i        (req_beat),
      .cmd_i        (dp_cmd),
      .stat_o       (dp_stat),
      .rsp_strobe_o (rsp_strobe),
      .rsp_o        (rsp_beat)
   );

   // single-beat commands answer with a final beat after the EDIT or SEARCH state and the response register
   assert property (@(posedge clock) disable iff (reset)
      (accept && (req_beat.cmd == CMD_INSERT || req_beat.cmd == CMD_DELETE ||
                  req_beat.cmd == CMD_UPDATE || req_beat.cmd == CMD_SEARCH))
      |-> ##2 (rsp_strobe && rsp_beat.last))
      else $error("single-beat command did not answer on time");

   // live count never exceeds the array depth
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_beat.count <= CNT_W'(DEPTH)))
      else $error("live count beyond depth");

   // the engine goes idle only together with the final beat of a command
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> (rsp_strobe && rsp_beat.last))
      else $error("engine went idle without a final beat");

endmodule
